@@ design/dbs_pkg.sv @@
// Shared types and constants of the deque and bag store.
`default_nettype none

package dbs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_QUERY      = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  // Status part of one result.
  typedef struct packed {
    logic found;
    st_t  status;
  } res_tag_t;

endpackage

`default_nettype wire

@@ design/dbs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/dbs_ctrl.sv @@
// Request sequencer: runs each operation as reads and writes on the slot memory.
`default_nettype none

module dbs_ctrl #(
  parameter int DEPTH = dbs_pkg::DEPTH_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request side
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [dbs_pkg::OP_W-1:0]     req_op,
  input  wire logic [dbs_pkg::VAL_W-1:0]    req_val,
  // result side
  output logic                              res_valid,
  input  wire logic                         res_take,
  output dbs_pkg::res_tag_t                 res_tag,
  output logic signed [dbs_pkg::VAL_W-1:0]  res_front,
  output logic signed [dbs_pkg::VAL_W-1:0]  res_back,
  output logic [CW-1:0]                     res_count,
  // slot memory
  output logic                              ram_we,
  output logic [IW-1:0]                     ram_waddr,
  output logic [dbs_pkg::VAL_W-1:0]         ram_wdata,
  output logic                              ram_re,
  output logic [IW-1:0]                     ram_raddr,
  input  wire logic [dbs_pkg::VAL_W-1:0]    ram_rdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EXEC  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_SHIFT = 8'b0000_1000,
    S_RDF   = 8'b0001_0000,
    S_RDB   = 8'b0010_0000,
    S_RDW   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t                      state_r, state_nxt;
  dbs_pkg::op_t                op_r, op_nxt;
  logic [dbs_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic [IW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               k_r, k_nxt;
  dbs_pkg::st_t                status_r, status_nxt;
  logic                        found_r, found_nxt;
  logic [dbs_pkg::VAL_W-1:0]   front_r, front_nxt;
  logic [dbs_pkg::VAL_W-1:0]   back_r, back_nxt;

  logic [CW-1:0] kp1, kp2, cnt_m1;
  logic [IW-1:0] head_dec, head_inc;
  logic          is_full, is_empty, scan_last, hit;

  // Physical slot of logical position k (k at most DEPTH).
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] k);
    logic [IW:0] sum;
    sum = {1'b0, head} + (IW+1)'(k);
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign kp1       = k_r + CW'(1);
  assign kp2       = k_r + CW'(2);
  assign cnt_m1    = count_r - CW'(1);
  assign head_dec  = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
  assign head_inc  = (head_r == IW'(DEPTH - 1)) ? '0 : head_r + IW'(1);
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign scan_last = (k_r == cnt_m1);
  assign hit       = (ram_rdata == val_r);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    val_nxt    = val_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    ram_we     = 1'b0;
    ram_waddr  = slot_of(head_r, k_r);
    ram_wdata  = val_r;
    ram_re     = 1'b0;
    ram_raddr  = slot_of(head_r, kp1);

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = dbs_pkg::op_t'(req_op);
          val_nxt    = req_val;
          status_nxt = dbs_pkg::ST_OK;
          found_nxt  = 1'b0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RDF;
        case (op_r)
          dbs_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
              status_nxt = dbs_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = head_dec;
              head_nxt  = head_dec;
              count_nxt = count_r + CW'(1);
            end
          end
          dbs_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
              status_nxt = dbs_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_of(head_r, count_r);
              count_nxt = count_r + CW'(1);
            end
          end
          dbs_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
              status_nxt = dbs_pkg::ST_EMPTY;
            end else begin
              head_nxt  = head_inc;
              count_nxt = cnt_m1;
            end
          end
          dbs_pkg::OP_POP_BACK: begin
            if (is_empty) begin
              status_nxt = dbs_pkg::ST_EMPTY;
            end else begin
              count_nxt = cnt_m1;
            end
          end
          dbs_pkg::OP_CONTAINS, dbs_pkg::OP_REMOVE: begin
            if (is_empty) begin
              if (op_r == dbs_pkg::OP_REMOVE) begin
                status_nxt = dbs_pkg::ST_EMPTY;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              k_nxt     = '0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // data of position k arrives; fetch k+1 in case it is needed
        ram_re = 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          if (op_r == dbs_pkg::OP_REMOVE) begin
            if (scan_last) begin
              count_nxt = cnt_m1;
              state_nxt = S_RDF;
            end else begin
              state_nxt = S_SHIFT;
            end
          end else begin
            state_nxt = S_RDF;
          end
        end else if (scan_last) begin
          state_nxt = S_RDF;
        end else begin
          k_nxt = kp1;
        end
      end
      S_SHIFT: begin
        // move position k+1 down to k, fetch k+2 unless k+1 was the last
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (kp1 == cnt_m1) begin
          count_nxt = cnt_m1;
          state_nxt = S_RDF;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(head_r, kp2);
          k_nxt     = kp1;
        end
      end
      S_RDF: begin
        if (is_empty) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = slot_of(head_r, cnt_m1);
        front_nxt = ram_rdata;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        back_nxt  = ram_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    val_r    <= val_nxt;
    k_r      <= k_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
  end

  assign req_ready      = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_FIN);
  assign res_tag.status = status_r;
  assign res_tag.found  = found_r;
  assign res_front      = front_r;
  assign res_back       = back_r;
  assign res_count      = count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count beyond depth");

  a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (op_r == dbs_pkg::OP_REMOVE) && found_r)
    else $error("shift without a matching remove");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1)))
    else $error("stored count moved by more than one");

endmodule

`default_nettype wire

@@ design/deque_bag_store_top.sv @@
// Top level of the deque and bag store: stream ports, slot memory and result register.
`default_nettype none

// Bounded double-ended queue of signed 32-bit values that doubles as a bag.
// Each request on the in_ stream carries an opcode (in_tuser) and a value
// (in_tdata): push front, push back, pop front, pop back, contains, remove
// first occurrence, or query (opcode seven acts as a query). Every request
// yields exactly one result on the out_ stream with status and found flag
// (out_tuser) and the front value, back value, entry count and empty flag
// after the operation (out_tdata). A push when full returns status full and
// a pop or remove when empty returns status empty; neither changes anything.
// The values sit in one DEPTH-entry slot memory used as a circular buffer,
// with one write and one registered read port. One request is in work at a
// time: after the operation, the front and back values are read back from
// the slot memory before the result is offered, a step skipped when the
// store is empty afterwards; contains and remove first scan the entries up
// to the match (or the whole store), and a removal then moves each later
// entry down one place. The slot memory has a single read port, so the
// scan reads one entry a cycle. A finished result waits in an output
// register while the next request is taken; the next request can be
// accepted in the cycle after the result moves into that register. The
// slot memory needs no clearing after reset.
module deque_bag_store_top #(
  parameter int DEPTH = dbs_pkg::DEPTH_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OUT_DW = ((2 * dbs_pkg::VAL_W + CW + 1 + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [dbs_pkg::VAL_W-1:0] in_tdata,   // [31:0] operand_value
  input  wire logic [dbs_pkg::OP_W-1:0]  in_tuser,   // [2:0] opcode
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [OUT_DW-1:0]              out_tdata,  // front_value, back_value,
                                                     // entry_count, is_empty, zero pad
  output logic [dbs_pkg::ST_W:0]         out_tuser   // [1:0] status, [2] found
);

  logic                             res_valid, res_take;
  dbs_pkg::res_tag_t                res_tag;
  logic signed [dbs_pkg::VAL_W-1:0] res_front, res_back;
  logic [CW-1:0]                    res_count;

  logic                      ram_we, ram_re;
  logic [IW-1:0]             ram_waddr, ram_raddr;
  logic [dbs_pkg::VAL_W-1:0] ram_wdata, ram_rdata;

  // result register, parts the request side from the result side
  logic                             out_tvalid_r, out_tvalid_nxt;
  dbs_pkg::res_tag_t                out_tag_r;
  logic signed [dbs_pkg::VAL_W-1:0] out_front_r, out_back_r;
  logic [CW-1:0]                    out_count_r;
  logic                             out_is_empty;

  dbs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tuser),
    .req_val   (in_tdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_tag   (res_tag),
    .res_front (res_front),
    .res_back  (res_back),
    .res_count (res_count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  dbs_ram #(
    .WIDTH (dbs_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // take the finished result when the register is free or being drained
  assign res_take = res_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_take) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // hold the payload until a new result is loaded
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tag_r   <= res_tag;
      out_front_r <= res_front;
      out_back_r  <= res_back;
      out_count_r <= res_count;
    end
  end

  assign out_is_empty = (out_count_r == '0);
  assign out_tvalid   = out_tvalid_r;
  assign out_tuser    = {out_tag_r.found, out_tag_r.status};
  assign out_tdata    = OUT_DW'({out_is_empty, out_count_r, out_back_r, out_front_r});

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_is_empty |-> (out_front_r == '0) && (out_back_r == '0))
    else $error("empty store reports a nonzero end value");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_tag_r.status == dbs_pkg::ST_FULL) |-> (out_count_r == CW'(DEPTH)))
    else $error("full status with store not full");

  a_found_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tag_r.found |-> (out_tag_r.status == dbs_pkg::ST_OK) && !out_is_empty
      || out_tvalid_r && out_tag_r.found && (out_tag_r.status == dbs_pkg::ST_OK))
    else $error("found flag with an error status");

endmodule

`default_nettype wire

@@ tb/deque_bag_store_top_tb.sv @@
// Self-checking testbench for the deque and bag store: directed corners, full-store and random requests.
module deque_bag_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_W      = dbs_pkg::VAL_W;
  localparam int OP_W       = dbs_pkg::OP_W;
  localparam int ST_W       = dbs_pkg::ST_W;
  localparam int CAPACITY   = dbs_pkg::DEPTH_DEF;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int OUT_W      = ((2 * VAL_W + CNT_W + 1 + 7) / 8) * 8;
  localparam int BACK_LSB   = VAL_W;
  localparam int COUNT_LSB  = 2 * VAL_W;
  localparam int EMPTY_BIT  = 2 * VAL_W + CNT_W;
  localparam int IDLE_LIMIT = 4000;  // longest hold-off plus a full scan, many times over
  localparam int SETTLE     = 100;
  localparam int PRINT_CAP  = 40;

  // Unused opcode, handled by the block as a query.
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  typedef struct packed {
    dbs_pkg::st_t     status;
    logic             found;
    logic [VAL_W-1:0] front;
    logic [VAL_W-1:0] back;
    logic [CNT_W-1:0] count;
    logic             empty;
  } deque_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [VAL_W-1:0]     in_tdata;   // [31:0] operand_value
  logic [OP_W-1:0]      in_tuser;   // [2:0] opcode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;  // [31:0] front, [63:32] back, [70:64] count, [71] empty
  logic [ST_W:0]        out_tuser;  // [1:0] status, [2] found

  // Values currently held, front first, and results still owed by the block.
  logic [VAL_W-1:0] held_values[$];
  deque_result_t    expected_results[$];

  int  mismatches;
  int  n_checked;
  int  n_accepted;
  int  n_refused_full;
  int  n_refused_empty;
  int  n_hits;
  int  n_reached_full;
  int  burst_left;
  bit  hold_off_req;
  int  hold_off_len;

  deque_bag_store_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the held values and work out the result it owes.
  function automatic deque_result_t predict_deque_result(logic [OP_W-1:0] op,
                                                         logic [VAL_W-1:0] val);
    deque_result_t res;
    int            hit;
    res = '0;
    res.status = dbs_pkg::ST_OK;
    hit = -1;
    case (op)
      dbs_pkg::OP_PUSH_FRONT, dbs_pkg::OP_PUSH_BACK: begin
        if (held_values.size() >= CAPACITY) begin
          res.status = dbs_pkg::ST_FULL;
        end else if (op == dbs_pkg::OP_PUSH_FRONT) begin
          held_values.push_front(val);
        end else begin
          held_values.push_back(val);
        end
      end
      dbs_pkg::OP_POP_FRONT, dbs_pkg::OP_POP_BACK: begin
        if (held_values.size() == 0) begin
          res.status = dbs_pkg::ST_EMPTY;
        end else if (op == dbs_pkg::OP_POP_FRONT) begin
          void'(held_values.pop_front());
        end else begin
          void'(held_values.pop_back());
        end
      end
      dbs_pkg::OP_CONTAINS, dbs_pkg::OP_REMOVE: begin
        if (op == dbs_pkg::OP_REMOVE && held_values.size() == 0) begin
          res.status = dbs_pkg::ST_EMPTY;
        end else begin
          // Search from the front; only the first match counts.
          for (int k = 0; k < held_values.size(); k++) begin
            if (hit < 0 && held_values[k] == val) hit = k;
          end
          res.found = (hit >= 0);
          if (op == dbs_pkg::OP_REMOVE && hit >= 0) held_values.delete(hit);
        end
      end
      default: begin
      end
    endcase
    if (held_values.size() != 0) begin
      res.front = held_values[0];
      res.back  = held_values[held_values.size() - 1];
    end
    res.count = CNT_W'(held_values.size());
    res.empty = (held_values.size() == 0);
    if (res.status == dbs_pkg::ST_FULL) n_refused_full++;
    if (res.status == dbs_pkg::ST_EMPTY) n_refused_empty++;
    if (res.found) n_hits++;
    if (held_values.size() == CAPACITY) n_reached_full++;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] result %0d: %s got %0h, expected %0h", $realtime, n_checked, what, got,
               want);
    mismatches++;
  endtask

  // Offer one request in bursts with random gaps; predict once it is taken.
  task automatic send_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = val;
    do @(posedge clk); while (!in_tready);
    n_accepted++;
    expected_results.push_back(predict_deque_result(op, val));
  endtask

  // Pause the sender until every owed result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Ask the receiver for a long stall; called at a rising edge.
  task automatic start_hold_off(int len);
    hold_off_len = len;
    hold_off_req = 1'b1;
  endtask

  // Operand choice: held values for hits, a narrow band for duplicates, extremes, anything.
  function automatic logic [VAL_W-1:0] pick_operand(int from_store_pct);
    int               r;
    logic [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    if (held_values.size() != 0 && r < from_store_pct)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = $urandom_range(0, 8);
      return v - 32'd4;
    end
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // Empty store: every request that needs an entry is refused or misses.
  task automatic test_empty_store();
    send_request(dbs_pkg::OP_QUERY, 32'h0);
    send_request(dbs_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
    send_request(dbs_pkg::OP_POP_BACK, 32'h0);
    send_request(dbs_pkg::OP_REMOVE, 32'h5);
    send_request(dbs_pkg::OP_CONTAINS, 32'h0);
    send_request(OP_SPARE, 32'h1234_5678);
  endtask

  // Extreme values, duplicates, first-match removal and removal of the last entry.
  task automatic test_extremes();
    send_request(dbs_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(dbs_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_request(dbs_pkg::OP_PUSH_BACK, 32'h0000_0000);
    send_request(dbs_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(dbs_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_request(dbs_pkg::OP_CONTAINS, 32'h8000_0000);
    send_request(dbs_pkg::OP_CONTAINS, 32'h0000_0001);
    send_request(dbs_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(dbs_pkg::OP_CONTAINS, 32'h8000_0000);
    send_request(dbs_pkg::OP_REMOVE, 32'h8000_0000);
    send_request(dbs_pkg::OP_REMOVE, 32'h0000_0001);
    send_request(dbs_pkg::OP_QUERY, 32'hFFFF_FFFF);
    send_request(dbs_pkg::OP_POP_FRONT, 32'h0);
    send_request(dbs_pkg::OP_POP_BACK, 32'h0);
    send_request(dbs_pkg::OP_REMOVE, 32'h7FFF_FFFF);
    send_request(OP_SPARE, 32'h0);
    wait_for_results();
  endtask

  // Fill behind a long receiver stall, refuse pushes when full, scan the whole store, drain.
  task automatic test_full_store();
    logic [VAL_W-1:0] v;
    start_hold_off(400);
    for (int i = 0; i < CAPACITY + 6; i++) begin
      v = pick_operand(10);
      send_request(($urandom_range(0, 1) != 0) ? dbs_pkg::OP_PUSH_FRONT : dbs_pkg::OP_PUSH_BACK,
                   v);
    end
    send_request(dbs_pkg::OP_CONTAINS, held_values[CAPACITY - 1]);
    send_request(dbs_pkg::OP_CONTAINS, 32'h5A5A_0F0F);
    send_request(dbs_pkg::OP_REMOVE, held_values[CAPACITY - 1]);
    send_request(dbs_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_request(dbs_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    while (held_values.size() != 0)
      send_request(($urandom_range(0, 1) != 0) ? dbs_pkg::OP_POP_FRONT : dbs_pkg::OP_POP_BACK,
                   $urandom);
    send_request(dbs_pkg::OP_POP_FRONT, $urandom);
    send_request(dbs_pkg::OP_POP_BACK, $urandom);
    wait_for_results();
  endtask

  // Random requests steered towards a fill level that moves between phases.
  task automatic test_random_mix(int n_items);
    int               target;
    int               phase_left;
    int               r;
    bit               flip;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    phase_left = 0;
    target = 0;
    for (int i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 90);
        r = $urandom_range(0, 3);
        target = (r == 0) ? 0 : (r == 1) ? CAPACITY : $urandom_range(1, CAPACITY - 1);
      end
      phase_left--;
      if (i % 400 == 200) start_hold_off($urandom_range(150, 400));
      if (i % 180 == 179) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 12) begin
        op = dbs_pkg::OP_CONTAINS;
      end else if (r < 24) begin
        op = dbs_pkg::OP_REMOVE;
      end else if (r < 28) begin
        op = dbs_pkg::OP_QUERY;
      end else if (r < 30) begin
        op = OP_SPARE;
      end else begin
        // Mostly head for the target; sometimes go the other way to hit full and empty.
        flip = ($urandom_range(0, 99) < 15);
        if ((held_values.size() < target) != flip)
          op = ($urandom_range(0, 1) != 0) ? dbs_pkg::OP_PUSH_FRONT : dbs_pkg::OP_PUSH_BACK;
        else
          op = ($urandom_range(0, 1) != 0) ? dbs_pkg::OP_POP_FRONT : dbs_pkg::OP_POP_BACK;
      end
      val = (op == dbs_pkg::OP_CONTAINS || op == dbs_pkg::OP_REMOVE) ? pick_operand(70)
                                                                     : pick_operand(10);
      send_request(op, val);
    end
  endtask

  // Receiver: stall patterns that change every so often, plus requested long hold-offs.
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    out_tready = 1'b0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready = 1'b0;
        repeat (hold_off_len) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 1) != 0);
          2:       out_tready = (tick % 4 == 0);
          default: out_tready = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // Compare each taken result with the oldest one owed.
  always @(posedge clk) begin : check_result
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing owed, front", out_tdata[VAL_W-1:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[ST_W-1:0] != want.status)
          report_mismatch("status", VAL_W'(out_tuser[ST_W-1:0]), VAL_W'(want.status));
        if (out_tuser[ST_W] != want.found)
          report_mismatch("found", VAL_W'(out_tuser[ST_W]), VAL_W'(want.found));
        if (out_tdata[VAL_W-1:0] != want.front)
          report_mismatch("front_value", out_tdata[VAL_W-1:0], want.front);
        if (out_tdata[BACK_LSB +: VAL_W] != want.back)
          report_mismatch("back_value", out_tdata[BACK_LSB +: VAL_W], want.back);
        if (out_tdata[COUNT_LSB +: CNT_W] != want.count)
          report_mismatch("entry_count", VAL_W'(out_tdata[COUNT_LSB +: CNT_W]),
                          VAL_W'(want.count));
        if (out_tdata[EMPTY_BIT] != want.empty)
          report_mismatch("is_empty", VAL_W'(out_tdata[EMPTY_BIT]), VAL_W'(want.empty));
      end
      n_checked++;
    end
  end

  // Watchdog: give up when nothing moves on either side for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    mismatches = 0;
    n_checked = 0;
    n_accepted = 0;
    n_refused_full = 0;
    n_refused_empty = 0;
    n_hits = 0;
    n_reached_full = 0;
    burst_left = 0;
    hold_off_req = 1'b0;
    hold_off_len = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_store();
    test_extremes();
    test_full_store();
    test_random_mix(1130);

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    while (expected_results.size() != 0) begin
      void'(expected_results.pop_front());
      report_mismatch("result never arrived, count", '0, '0);
    end

    $display("Covered %0d requests and %0d results: %0d pushes refused when full,",
             n_accepted, n_checked, n_refused_full);
    $display("  %0d pops or removes refused when empty, %0d hits, %0d times at full depth.",
             n_refused_empty, n_hits, n_reached_full);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
